/* sv/tpdb_pkg.sv */
// Package for the tile pattern dedup bank: sizes, controller states and the
// command and status bundles between controller and datapath. No dependencies.
package tpdb_pkg;

  localparam int BANK_ENTRIES = 256;
  localparam int IDX_W  = $clog2(BANK_ENTRIES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int PAT_W  = 64;
  localparam int TIDX_W = 8;

  typedef logic [PAT_W-1:0]  pat_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIDX_W-1:0] tidx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic latch_hit;
    logic latch_miss;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic done;
    logic out_free;
  } sts_t;

  function automatic tidx_t to_tidx(input cnt_t v);
    logic [CNT_W+TIDX_W-1:0] ext;
    ext = {{TIDX_W{1'b0}}, v};
    return ext[TIDX_W-1:0];
  endfunction

endpackage

/* sv/tile_pattern_dedup_bank_top.sv */
// Top level of the tile pattern dedup bank: joins controller and datapath.
// Depends on tpdb_pkg, tpdb_ctrl and tpdb_dp.
//
//   channel | ports                                   | role
//   in      | in_valid in_ready in_tile_pattern[63:0] | pattern request
//   out     | out_valid out_ready out_tile_index[7:0] | index and full flag
//           | out_bank_full                           |
//
// A miss goes through load, one memory read per valid entry through the single
// comparator, the last compare, the commit and the emit; a hit on entry j ends
// the scan at the compare on that entry, latches its result and goes to emit.
// Reset is synchronous, active low; the bank then holds only entry 0 (zeros).
// A new request is taken while the previous result waits on out_ready.
module tile_pattern_dedup_bank_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          in_tile_pattern,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_tile_index,
  output logic                 out_bank_full
);

  tpdb_pkg::cmd_t cmd;
  tpdb_pkg::sts_t sts;

  tpdb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpdb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tile_pattern (in_tile_pattern),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tile_index  (out_tile_index),
    .out_bank_full   (out_bank_full)
  );

endmodule

/* sv/tpdb_ctrl.sv */
// Controller for the tile pattern dedup bank: sequences load, scan and emit.
// Depends on tpdb_pkg.
module tpdb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tpdb_pkg::sts_t  sts,
  output tpdb_pkg::cmd_t  cmd
);

  tpdb_pkg::state_t state_r, state_nxt;

  assign in_ready = (state_r == tpdb_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      tpdb_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tpdb_pkg::ST_SCAN;
        end
      end
      tpdb_pkg::ST_SCAN: begin
        if (sts.hit) begin
          cmd.latch_hit = 1'b1;
          state_nxt     = tpdb_pkg::ST_EMIT;
        end else if (sts.done) begin
          cmd.latch_miss = 1'b1;
          state_nxt      = tpdb_pkg::ST_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      tpdb_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = tpdb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tpdb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpdb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/tpdb_dp.sv */
// Datapath for the tile pattern dedup bank: pattern memory, fill count, scan
// pointer, one comparator and the output register. Depends on tpdb_pkg.
module tpdb_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tpdb_pkg::pat_t         in_tile_pattern,
  input  tpdb_pkg::cmd_t         cmd,
  output tpdb_pkg::sts_t         sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tpdb_pkg::tidx_t        out_tile_index,
  output logic                   out_bank_full
);

  localparam tpdb_pkg::cnt_t FULL_CNT = tpdb_pkg::CNT_W'(tpdb_pkg::BANK_ENTRIES);

  tpdb_pkg::pat_t  mem [tpdb_pkg::BANK_ENTRIES];

  tpdb_pkg::pat_t  pat_r;
  tpdb_pkg::cnt_t  count_r;
  tpdb_pkg::cnt_t  k_r;
  tpdb_pkg::pat_t  rd_data_r;
  tpdb_pkg::idx_t  rd_idx_r;
  logic            rd_vld_r;
  tpdb_pkg::tidx_t res_idx_r;
  logic            res_full_r;
  logic            out_valid_r;
  tpdb_pkg::tidx_t out_idx_r;
  logic            out_full_r;

  logic            entry_eq;
  logic            can_insert;

  // entry zero is the fixed all-zero pattern and is never stored
  assign entry_eq   = (rd_idx_r == '0) ? (pat_r == '0) : (rd_data_r == pat_r);
  assign can_insert = (count_r < FULL_CNT);

  assign sts.hit      = rd_vld_r && entry_eq;
  assign sts.done     = (k_r == count_r) && !rd_vld_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_tile_index = out_idx_r;
  assign out_bank_full  = out_full_r;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[k_r[tpdb_pkg::IDX_W-1:0]];
    if (cmd.latch_miss && can_insert) begin
      mem[count_r[tpdb_pkg::IDX_W-1:0]] <= pat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat_r <= in_tile_pattern;
    end
    rd_idx_r <= k_r[tpdb_pkg::IDX_W-1:0];
    if (cmd.latch_hit) begin
      res_idx_r  <= tpdb_pkg::to_tidx({1'b0, rd_idx_r});
      res_full_r <= 1'b0;
    end else if (cmd.latch_miss) begin
      res_idx_r  <= can_insert ? tpdb_pkg::to_tidx(count_r) : '0;
      res_full_r <= !can_insert;
    end
    if (cmd.emit) begin
      out_idx_r  <= res_idx_r;
      out_full_r <= res_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= tpdb_pkg::CNT_W'(1);
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        k_r      <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.step && (k_r < count_r)) begin
        k_r      <= k_r + tpdb_pkg::CNT_W'(1);
        rd_vld_r <= 1'b1;
      end else begin
        rd_vld_r <= 1'b0;
      end
      if (cmd.latch_miss && can_insert) begin
        count_r <= count_r + tpdb_pkg::CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= FULL_CNT))
    else $error("fill count out of range");

  a_read_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ({1'b0, rd_idx_r} < count_r))
    else $error("compare on an entry beyond the fill count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.latch_miss && can_insert) |=> (count_r == $past(count_r) + tpdb_pkg::CNT_W'(1)))
    else $error("insert did not advance fill count");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (out_idx_r == '0))
    else $error("full result with nonzero index");

endmodule
